// ===== rtl/assert_macros.svh =====
// Assertion macros for the DRAM bank command scheduler checkers.
// Used by any file that writes concurrent assertions on clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DBCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DBCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dbcs_pkg.sv =====
// Shared types, field widths and codes for the DRAM bank command scheduler.
// No dependencies; used by every RTL module of the block.
package dbcs_pkg;

	// Default geometry
	localparam int DEF_RANKS       = 4;
	localparam int DEF_BANKS       = 8;
	localparam int DEF_QUEUE_DEPTH = 16;

	// Field widths
	localparam int MODE_W    = 2;
	localparam int RCNT_W    = 3;
	localparam int BCNT_W    = 4;
	localparam int RANK_W    = 2;
	localparam int BANK_W    = 3;
	localparam int KIND_W    = 2;
	localparam int STAMP_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 4;
	localparam int CNT_W     = RCNT_W + BCNT_W + 1;

	// Input command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_ISSUE   = 1'b1;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_RAS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_ISSUED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOTHING  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NO_CAS   = 3'd4;

	// Ordering modes
	localparam logic [MODE_W-1:0] MODE_OLDEST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RANK_RR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BANK_RR = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORDERING_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANKS_IN_USE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BANKS_IN_USE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_RW      = 3'd3;

	// Configuration reset values
	localparam logic [MODE_W-1:0] RST_MODE  = MODE_OLDEST;
	localparam int                RST_RANKS = 4;
	localparam int                RST_BANKS = 8;
	localparam logic              RST_GROUP = 1'b0;

	// One queue entry
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Write request into the entry store
	typedef struct packed {
		logic   en;
		entry_t data;
	} entry_wr_t;

endpackage

// ===== rtl/dbcs_qmem.sv =====
// Command queue entry store: full entries read at the head, kinds read at head plus one.
// Depends on dbcs_pkg for the entry types.
module dbcs_qmem #(
	parameter int DEPTH = dbcs_pkg::DEF_RANKS * dbcs_pkg::DEF_BANKS * dbcs_pkg::DEF_QUEUE_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  dbcs_pkg::entry_wr_t           wr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [AW-1:0]                 rd_addr_head,
	input  logic [AW-1:0]                 rd_addr_next,
	output dbcs_pkg::entry_t              rd_head,
	output logic [dbcs_pkg::KIND_W-1:0]   rd_next_kind
);

	dbcs_pkg::entry_t            ent_mem  [DEPTH];
	logic [dbcs_pkg::KIND_W-1:0] kind_mem [DEPTH];

	// Write both copies, read head entry and the kind behind it
	always_ff @(posedge clk) begin
		if (wr.en) begin
			ent_mem[wr_addr]  <= wr.data;
			kind_mem[wr_addr] <= wr.data.kind;
		end
		rd_head      <= ent_mem[rd_addr_head];
		rd_next_kind <= kind_mem[rd_addr_next];
	end

endmodule

// ===== rtl/dram_bank_command_scheduler.sv =====
// DRAM bank command scheduler for one channel.
// Channels: input beats (command, rank, bank, kind, stamp) on in_valid/in_stall,
// result beats (status, out_rank, out_bank, out_kind, out_stamp) on out_valid/out_stall,
// configuration writes on cfg_valid/cfg_ready with cfg_index and cfg_data.
// cfg_ready is always high; the user must make writes only while the block is idle, which the
// block does not enforce. One result beat per input beat, in order. One item is in work at a time:
// in_stall is high from acceptance until the result is placed in the output register.
// Enqueue passes through the ENQ and DONE states. Issue, oldest first, sweeps every queue
// head in SCAN; round robin first folds a stale last position in PREP and may sweep the
// heads twice. A RAS follow-up check goes through RAS0 and RAS1 instead of the sweep.
// The probe loop reads one queue head per cycle through the entry memory read port.
// Reset clears queue heads and fill counts and sets the last issued command and
// configuration to their reset values; entry contents are not cleared. While out_stall
// is high the result is held and the next result waits in the sequencer.
// Depends on dbcs_pkg and dbcs_qmem.
module dram_bank_command_scheduler #(
	parameter int RANKS       = dbcs_pkg::DEF_RANKS,
	parameter int BANKS       = dbcs_pkg::DEF_BANKS,
	parameter int QUEUE_DEPTH = dbcs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [dbcs_pkg::RANK_W-1:0]       rank,
	input  logic [dbcs_pkg::BANK_W-1:0]       bank,
	input  logic [dbcs_pkg::KIND_W-1:0]       kind,
	input  logic [dbcs_pkg::STAMP_W-1:0]      stamp,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [dbcs_pkg::STATUS_W-1:0]     status,
	output logic [dbcs_pkg::RANK_W-1:0]       out_rank,
	output logic [dbcs_pkg::BANK_W-1:0]       out_bank,
	output logic [dbcs_pkg::KIND_W-1:0]       out_kind,
	output logic [dbcs_pkg::STAMP_W-1:0]      out_stamp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dbcs_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int NQ     = RANKS * BANKS;
	localparam int QW     = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int HW     = $clog2(QUEUE_DEPTH);
	localparam int FW     = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH  = NQ * QUEUE_DEPTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int RW     = dbcs_pkg::RCNT_W;
	localparam int BW     = dbcs_pkg::BCNT_W;
	localparam int CW     = dbcs_pkg::CNT_W;
	localparam int RST_NR = (dbcs_pkg::RST_RANKS > RANKS) ? RANKS : dbcs_pkg::RST_RANKS;
	localparam int RST_NB = (dbcs_pkg::RST_BANKS > BANKS) ? BANKS : dbcs_pkg::RST_BANKS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENQ  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_RAS0 = 3'd4;
	localparam logic [2:0] ST_RAS1 = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	function automatic logic [QW-1:0] qidx(input logic [RW-1:0] r, input logic [BW-1:0] b);
		return QW'(int'(r) * BANKS + int'(b));
	endfunction

	function automatic logic [AW-1:0] maddr(input logic [QW-1:0] q, input logic [HW-1:0] h);
		return AW'(int'(q) * QUEUE_DEPTH + int'(h));
	endfunction

	// Configuration registers
	logic [dbcs_pkg::MODE_W-1:0] mode_q;
	logic [RW-1:0]               ranks_q;
	logic [BW-1:0]               banks_q;
	logic                        group_q;

	// Latched input beat
	logic [dbcs_pkg::RANK_W-1:0]  rank_in_q;
	logic [dbcs_pkg::BANK_W-1:0]  bank_in_q;
	logic [dbcs_pkg::KIND_W-1:0]  kind_in_q;
	logic [dbcs_pkg::STAMP_W-1:0] stamp_in_q;

	// Sequencer
	logic [2:0]    state_q;
	logic [RW-1:0] pos_r_q;
	logic [BW-1:0] pos_b_q;
	logic          dir_q;
	logic [CW-1:0] cnt_q;
	logic          found_q;
	logic          ras_q;

	// Probe stage
	logic          valid_s1;
	logic [RW-1:0] r_s1;
	logic [BW-1:0] b_s1;
	logic [FW-1:0] fill_s1;
	logic          dir_s1;

	// Selected command
	logic [RW-1:0]                sel_r_q;
	logic [BW-1:0]                sel_b_q;
	logic [dbcs_pkg::KIND_W-1:0]  sel_kind_q;
	logic [dbcs_pkg::STAMP_W-1:0] sel_stamp_q;

	// Last issued command
	logic [RW-1:0]               last_r_q;
	logic [BW-1:0]               last_b_q;
	logic [dbcs_pkg::KIND_W-1:0] last_k_q;

	// Queue pointers
	logic [HW-1:0] head_q [NQ];
	logic [FW-1:0] fill_q [NQ];

	// Pending result and output register
	logic [dbcs_pkg::STATUS_W-1:0] res_status_q;
	logic [dbcs_pkg::RANK_W-1:0]   res_rank_q;
	logic [dbcs_pkg::BANK_W-1:0]   res_bank_q;
	logic [dbcs_pkg::KIND_W-1:0]   res_kind_q;
	logic [dbcs_pkg::STAMP_W-1:0]  res_stamp_q;
	logic                          out_valid_q;
	logic [dbcs_pkg::STATUS_W-1:0] out_status_q;
	logic [dbcs_pkg::RANK_W-1:0]   out_rank_q;
	logic [dbcs_pkg::BANK_W-1:0]   out_bank_q;
	logic [dbcs_pkg::KIND_W-1:0]   out_kind_q;
	logic [dbcs_pkg::STAMP_W-1:0]  out_stamp_q;

	// Combinational
	logic [RW-1:0]        nr;
	logic [BW-1:0]        nb;
	logic                 mode_rr;
	logic [CW-1:0]        limit;
	logic [RW-1:0]        r_inc, step_r;
	logic [BW-1:0]        b_inc, step_b;
	logic                 step_dir;
	logic [QW-1:0]        idx;
	logic [FW-1:0]        fill_cur;
	logic [HW-1:0]        head_cur, head_nxt, tail;
	logic [FW:0]          tsum;
	logic                 enq_bad;
	logic                 slot_free;
	dbcs_pkg::entry_wr_t  wr;
	dbcs_pkg::entry_t     rd_head;
	logic [dbcs_pkg::KIND_W-1:0] rd_next_kind;
	logic                 elig_rr;
	logic                 older;

	// Clamp the counts in use
	always_comb begin
		if (ranks_q == '0)
			nr = RW'(1);
		else if (int'(ranks_q) > RANKS)
			nr = RW'(RANKS);
		else
			nr = ranks_q;
		if (banks_q == '0)
			nb = BW'(1);
		else if (int'(banks_q) > BANKS)
			nb = BW'(BANKS);
		else
			nb = banks_q;
	end

	assign mode_rr = (mode_q == dbcs_pkg::MODE_RANK_RR) || (mode_q == dbcs_pkg::MODE_BANK_RR);
	assign limit   = mode_rr ? ((CW'(nr) * CW'(nb)) << 1) : (CW'(nr) * CW'(nb));

	// Advance the sweep position by one queue
	always_comb begin
		r_inc = (pos_r_q + RW'(1) == nr) ? '0 : pos_r_q + RW'(1);
		b_inc = (pos_b_q + BW'(1) == nb) ? '0 : pos_b_q + BW'(1);
		if (mode_q == dbcs_pkg::MODE_RANK_RR) begin
			step_r   = r_inc;
			step_b   = (r_inc == '0) ? b_inc : pos_b_q;
			step_dir = dir_q ^ ((r_inc == '0) && (b_inc == '0));
		end else begin
			step_b   = b_inc;
			step_r   = (b_inc == '0) ? r_inc : pos_r_q;
			step_dir = dir_q ^ ((b_inc == '0) && (r_inc == '0));
		end
	end

	// Select the queue whose pointers are read this cycle
	always_comb begin
		case (state_q)
			ST_ENQ:  idx = qidx(RW'(rank_in_q), BW'(bank_in_q));
			ST_FIN:  idx = qidx(sel_r_q, sel_b_q);
			ST_RAS0: idx = qidx(last_r_q, last_b_q);
			default: idx = qidx(step_r, step_b);
		endcase
	end

	assign fill_cur = (int'(idx) < NQ) ? fill_q[idx] : '0;
	assign head_cur = (int'(idx) < NQ) ? head_q[idx] : '0;
	assign head_nxt = (head_cur == HW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + HW'(1);
	assign tsum     = (FW+1)'(head_cur) + (FW+1)'(fill_cur);
	assign tail     = (int'(tsum) >= QUEUE_DEPTH) ? HW'(int'(tsum) - QUEUE_DEPTH) : HW'(tsum);

	assign enq_bad = (RW'(rank_in_q) >= nr) || (BW'(bank_in_q) >= nb)
		|| (kind_in_q > dbcs_pkg::KIND_WRITE) || (fill_cur == FW'(QUEUE_DEPTH));

	// Entry store write
	always_comb begin
		wr.en         = (state_q == ST_ENQ) && !enq_bad;
		wr.data.kind  = kind_in_q;
		wr.data.stamp = stamp_in_q;
	end

	dbcs_qmem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_qmem (
		.clk          (clk),
		.wr           (wr),
		.wr_addr      (maddr(idx, tail)),
		.rd_addr_head (maddr(idx, head_cur)),
		.rd_addr_next (maddr(idx, head_nxt)),
		.rd_head      (rd_head),
		.rd_next_kind (rd_next_kind)
	);

	// Probe evaluation
	assign elig_rr = (fill_s1 != '0) && (!group_q || (fill_s1 < FW'(2))
		|| (dir_s1 ? (rd_next_kind == dbcs_pkg::KIND_WRITE)
		           : (rd_next_kind == dbcs_pkg::KIND_READ)));
	assign older   = (fill_s1 != '0) && (!found_q || (rd_head.stamp < sel_stamp_q));

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dbcs_pkg::RST_MODE;
			ranks_q <= RW'(dbcs_pkg::RST_RANKS);
			banks_q <= BW'(dbcs_pkg::RST_BANKS);
			group_q <= dbcs_pkg::RST_GROUP;
		end else if (cfg_valid) begin
			case (cfg_index)
				dbcs_pkg::CFG_ORDERING_MODE: mode_q  <= cfg_data[dbcs_pkg::MODE_W-1:0];
				dbcs_pkg::CFG_RANKS_IN_USE:  ranks_q <= cfg_data[RW-1:0];
				dbcs_pkg::CFG_BANKS_IN_USE:  banks_q <= cfg_data[BW-1:0];
				dbcs_pkg::CFG_GROUP_RW:      group_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Latch the input beat
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rank_in_q  <= rank;
			bank_in_q  <= bank;
			kind_in_q  <= kind;
			stamp_in_q <= stamp;
		end
	end

	// Sequencer: enqueue, sweep the queue heads, issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_r_q      <= '0;
			pos_b_q      <= '0;
			dir_q        <= 1'b0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			ras_q        <= 1'b0;
			valid_s1     <= 1'b0;
			r_s1         <= '0;
			b_s1         <= '0;
			fill_s1      <= '0;
			dir_s1       <= 1'b0;
			sel_r_q      <= '0;
			sel_b_q      <= '0;
			sel_kind_q   <= '0;
			sel_stamp_q  <= '0;
			last_r_q     <= RW'(RST_NR - 1);
			last_b_q     <= BW'(RST_NB - 1);
			last_k_q     <= dbcs_pkg::KIND_WRITE;
			res_status_q <= '0;
			res_rank_q   <= '0;
			res_bank_q   <= '0;
			res_kind_q   <= '0;
			res_stamp_q  <= '0;
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			valid_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
						ras_q   <= 1'b0;
						cnt_q   <= '0;
						if (command == dbcs_pkg::CMD_ENQUEUE) begin
							state_q <= ST_ENQ;
						end else if (mode_rr && (last_k_q == dbcs_pkg::KIND_RAS)) begin
							ras_q   <= 1'b1;
							state_q <= ST_RAS0;
						end else if (mode_rr) begin
							pos_r_q <= last_r_q;
							pos_b_q <= last_b_q;
							dir_q   <= (last_k_q != dbcs_pkg::KIND_READ);
							state_q <= ST_PREP;
						end else begin
							// start just before rank 0, bank 0
							pos_r_q <= nr - RW'(1);
							pos_b_q <= nb - BW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ENQ: begin
					res_status_q <= enq_bad ? dbcs_pkg::STAT_DROPPED : dbcs_pkg::STAT_ENQUEUED;
					res_rank_q   <= '0;
					res_bank_q   <= '0;
					res_kind_q   <= '0;
					res_stamp_q  <= '0;
					if (!enq_bad)
						fill_q[idx] <= fill_cur + FW'(1);
					state_q <= ST_DONE;
				end
				ST_PREP: begin
					// fold a stale last position into the counts in use
					if (pos_r_q < nr && pos_b_q < nb)
						state_q <= ST_SCAN;
					if (pos_r_q >= nr)
						pos_r_q <= pos_r_q - nr;
					if (pos_b_q >= nb)
						pos_b_q <= pos_b_q - nb;
				end
				ST_SCAN: begin
					// launch one probe a cycle
					if (cnt_q != limit) begin
						pos_r_q  <= step_r;
						pos_b_q  <= step_b;
						dir_q    <= step_dir;
						cnt_q    <= cnt_q + CW'(1);
						valid_s1 <= 1'b1;
						r_s1     <= step_r;
						b_s1     <= step_b;
						fill_s1  <= fill_cur;
						dir_s1   <= step_dir;
					end
					// evaluate the probe launched last cycle
					if (valid_s1 && mode_rr) begin
						if (elig_rr) begin
							found_q     <= 1'b1;
							sel_r_q     <= r_s1;
							sel_b_q     <= b_s1;
							sel_kind_q  <= rd_head.kind;
							sel_stamp_q <= rd_head.stamp;
							state_q     <= ST_FIN;
						end
					end else if (valid_s1 && older) begin
						found_q     <= 1'b1;
						sel_r_q     <= r_s1;
						sel_b_q     <= b_s1;
						sel_kind_q  <= rd_head.kind;
						sel_stamp_q <= rd_head.stamp;
					end
					if (cnt_q == limit && !valid_s1)
						state_q <= ST_FIN;
				end
				ST_RAS0: begin
					valid_s1 <= 1'b1;
					r_s1     <= last_r_q;
					b_s1     <= last_b_q;
					fill_s1  <= fill_cur;
					state_q  <= ST_RAS1;
				end
				ST_RAS1: begin
					// a RAS must be followed by a CAS of the same bank
					if (fill_s1 != '0 && (rd_head.kind == dbcs_pkg::KIND_READ
						|| rd_head.kind == dbcs_pkg::KIND_WRITE)) begin
						found_q     <= 1'b1;
						sel_r_q     <= r_s1;
						sel_b_q     <= b_s1;
						sel_kind_q  <= rd_head.kind;
						sel_stamp_q <= rd_head.stamp;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (found_q) begin
						head_q[idx]  <= head_nxt;
						fill_q[idx]  <= fill_cur - FW'(1);
						last_r_q     <= sel_r_q;
						last_b_q     <= sel_b_q;
						last_k_q     <= sel_kind_q;
						res_status_q <= dbcs_pkg::STAT_ISSUED;
						res_rank_q   <= sel_r_q[dbcs_pkg::RANK_W-1:0];
						res_bank_q   <= sel_b_q[dbcs_pkg::BANK_W-1:0];
						res_kind_q   <= sel_kind_q;
						res_stamp_q  <= sel_stamp_q;
					end else begin
						res_status_q <= ras_q ? dbcs_pkg::STAT_NO_CAS : dbcs_pkg::STAT_NOTHING;
						res_rank_q   <= '0;
						res_bank_q   <= '0;
						res_kind_q   <= '0;
						res_stamp_q  <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: drop on take, set when a result moves in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (state_q == ST_DONE && slot_free)
				out_valid_q <= 1'b1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_status_q <= res_status_q;
			out_rank_q   <= res_rank_q;
			out_bank_q   <= res_bank_q;
			out_kind_q   <= res_kind_q;
			out_stamp_q  <= res_stamp_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_rank  = out_rank_q;
	assign out_bank  = out_bank_q;
	assign out_kind  = out_kind_q;
	assign out_stamp = out_stamp_q;

endmodule

// ===== rtl/dbcs_checker.sv =====
// Port-level checker for the DRAM bank command scheduler, bound to the top level.
// Depends on dbcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbcs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [dbcs_pkg::STATUS_W-1:0]     status,
	input logic [dbcs_pkg::RANK_W-1:0]       out_rank,
	input logic [dbcs_pkg::BANK_W-1:0]       out_bank,
	input logic [dbcs_pkg::KIND_W-1:0]       out_kind,
	input logic [dbcs_pkg::STAMP_W-1:0]      out_stamp
);

	logic non_issue;
	logic fields_zero;

	assign non_issue   = out_valid && (status != dbcs_pkg::STAT_ISSUED);
	assign fields_zero = (out_rank == '0) && (out_bank == '0) && (out_kind == '0)
		&& (out_stamp == '0);

	// Non-issue results carry no command
	`DBCS_ASSERT_IMP(a_idle_fields, non_issue, fields_zero, "non-issue result carries fields")

	// Issued commands have a legal kind
	`DBCS_ASSERT_IMP(a_issue_kind, !non_issue && out_valid, out_kind <= dbcs_pkg::KIND_WRITE, "illegal kind")

	// One item in work: an accepted beat stalls the next
	`DBCS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

	// A stalled result stays offered
	`DBCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result withdrawn")

endmodule

bind dram_bank_command_scheduler dbcs_checker u_dbcs_checker (.*);

// ===== tb/sv/tb_dram_bank_command_scheduler.sv =====
// Self-checking testbench for dram_bank_command_scheduler: directed and random traffic
// checked beat by beat against a behavioural scheduler model kept inside this file.
// Depends on dbcs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_dram_bank_command_scheduler;
	import dbcs_pkg::*;

	localparam int NR = 4;
	localparam int NB = 8;
	localparam int QD = 16;
	localparam int NQ = NR * NB;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RANK_W-1:0]   rank;
		logic [BANK_W-1:0]   bank;
		logic [KIND_W-1:0]   kind;
		logic [STAMP_W-1:0]  stamp;
	} sched_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_ENQUEUE;
	logic [RANK_W-1:0] rank = '0;
	logic [BANK_W-1:0] bank = '0;
	logic [KIND_W-1:0] kind = '0;
	logic [STAMP_W-1:0] stamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [RANK_W-1:0] out_rank;
	logic [BANK_W-1:0] out_bank;
	logic [KIND_W-1:0] out_kind;
	logic [STAMP_W-1:0] out_stamp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	dram_bank_command_scheduler dut (.*);

	always #5 clk = ~clk;

	// Scheduler state as predicted
	logic [KIND_W-1:0]  sh_kind  [NQ][QD];
	logic [STAMP_W-1:0] sh_stamp [NQ][QD];
	int sh_head [NQ];
	int sh_fill [NQ];
	int last_r = 3;
	int last_b = 7;
	logic [KIND_W-1:0] last_k = KIND_WRITE;
	logic [MODE_W-1:0] cur_mode = MODE_OLDEST;
	int cur_ranks = 4;
	int cur_banks = 8;
	logic cur_group = 1'b0;

	sched_beat_t pending_results[$];
	int errors = 0;
	int burst_left = 0;
	int gap_max = 0;
	logic [15:0] stall_pat = '0;
	logic [STAMP_W-1:0] stamp_clock = '0;

	initial begin
		for (int q = 0; q < NQ; q++) begin
			sh_head[q] = 0;
			sh_fill[q] = 0;
		end
	end

	function automatic int eff_ranks();
		return (cur_ranks < 1) ? 1 : (cur_ranks > NR) ? NR : cur_ranks;
	endfunction

	function automatic int eff_banks();
		return (cur_banks < 1) ? 1 : (cur_banks > NB) ? NB : cur_banks;
	endfunction

	// Pop one queue head and record it as the last issued command
	function automatic sched_beat_t pop_head(int r, int b);
		sched_beat_t res;
		int q;
		q = r * NB + b;
		res.status = STAT_ISSUED;
		res.rank = r[RANK_W-1:0];
		res.bank = b[BANK_W-1:0];
		res.kind = sh_kind[q][sh_head[q]];
		res.stamp = sh_stamp[q][sh_head[q]];
		sh_head[q] = (sh_head[q] + 1) % QD;
		sh_fill[q]--;
		last_r = r;
		last_b = b;
		last_k = res.kind;
		return res;
	endfunction

	function automatic bit head_ready(int r, int b, bit dir_w);
		int q;
		logic [KIND_W-1:0] nxt;
		q = r * NB + b;
		if (sh_fill[q] == 0) return 1'b0;
		if (!cur_group || sh_fill[q] < 2) return 1'b1;
		nxt = sh_kind[q][(sh_head[q] + 1) % QD];
		return dir_w ? (nxt == KIND_WRITE) : (nxt == KIND_READ);
	endfunction

	function automatic sched_beat_t pick_command();
		sched_beat_t res;
		int nr, nb, r, b, q, br, bb;
		bit found, dir_w;
		logic [STAMP_W-1:0] bs;
		res = '0;
		nr = eff_ranks();
		nb = eff_banks();
		// Oldest first, also for the unused mode
		if (cur_mode != MODE_RANK_RR && cur_mode != MODE_BANK_RR) begin
			found = 1'b0;
			br = 0;
			bb = 0;
			bs = '0;
			for (r = 0; r < nr; r++)
				for (b = 0; b < nb; b++) begin
					q = r * NB + b;
					if (sh_fill[q] != 0 &&
							(!found || sh_stamp[q][sh_head[q]] < bs)) begin
						found = 1'b1;
						br = r;
						bb = b;
						bs = sh_stamp[q][sh_head[q]];
					end
				end
			if (!found) res.status = STAT_NOTHING;
			else res = pop_head(br, bb);
			return res;
		end
		// A RAS must be followed by the CAS of the same bank
		if (last_k == KIND_RAS) begin
			q = last_r * NB + last_b;
			if (sh_fill[q] != 0 && (sh_kind[q][sh_head[q]] == KIND_READ ||
					sh_kind[q][sh_head[q]] == KIND_WRITE))
				res = pop_head(last_r, last_b);
			else
				res.status = STAT_NO_CAS;
			return res;
		end
		// Round-robin sweep; direction flips on each wrap to the origin
		dir_w = (last_k != KIND_READ);
		r = last_r % nr;
		b = last_b % nb;
		for (int i = 0; i < 2 * nr * nb; i++) begin
			if (cur_mode == MODE_RANK_RR) begin
				r = (r + 1) % nr;
				if (r == 0) begin
					b = (b + 1) % nb;
					if (b == 0) dir_w = !dir_w;
				end
			end else begin
				b = (b + 1) % nb;
				if (b == 0) begin
					r = (r + 1) % nr;
					if (r == 0) dir_w = !dir_w;
				end
			end
			if (head_ready(r, b, dir_w)) return pop_head(r, b);
		end
		res.status = STAT_NOTHING;
		return res;
	endfunction

	function automatic sched_beat_t schedule_item(logic cmd, logic [RANK_W-1:0] r,
			logic [BANK_W-1:0] b, logic [KIND_W-1:0] k, logic [STAMP_W-1:0] s);
		sched_beat_t res;
		int q, tail;
		res = '0;
		if (cmd == CMD_ISSUE) return pick_command();
		q = r * NB + b;
		if (r >= eff_ranks() || b >= eff_banks() || k > KIND_WRITE || sh_fill[q] >= QD) begin
			res.status = STAT_DROPPED;
			return res;
		end
		tail = (sh_head[q] + sh_fill[q]) % QD;
		sh_kind[q][tail] = k;
		sh_stamp[q][tail] = s;
		sh_fill[q]++;
		res.status = STAT_ENQUEUED;
		return res;
	endfunction

	// Send one beat, with a random gap between bursts
	task automatic send_cmd(logic cmd, logic [RANK_W-1:0] r, logic [BANK_W-1:0] b,
			logic [KIND_W-1:0] k, logic [STAMP_W-1:0] s);
		if (burst_left <= 0) begin
			if (gap_max > 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(0, gap_max)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		command = cmd;
		rank = r;
		bank = b;
		kind = k;
		stamp = s;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(schedule_item(cmd, r, b, k, s));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic issue_one();
		send_cmd(CMD_ISSUE, RANK_W'($urandom), BANK_W'($urandom), KIND_W'($urandom),
			$urandom);
	endtask

	// Hold input idle until every result beat has arrived
	task automatic drain();
		in_valid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ORDERING_MODE: cur_mode = val[MODE_W-1:0];
			CFG_RANKS_IN_USE:  cur_ranks = val[RCNT_W-1:0];
			CFG_BANKS_IN_USE:  cur_banks = val[BCNT_W-1:0];
			CFG_GROUP_RW:      cur_group = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(logic [MODE_W-1:0] m, logic [CFG_DAT_W-1:0] nr,
			logic [CFG_DAT_W-1:0] nb, logic g);
		drain();
		write_reg(CFG_ORDERING_MODE, {2'b00, m});
		write_reg(CFG_RANKS_IN_USE, nr);
		write_reg(CFG_BANKS_IN_USE, nb);
		write_reg(CFG_GROUP_RW, {3'b000, g});
	endtask

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		sched_beat_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, out_rank, out_bank, out_kind, out_stamp};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Receiver stall pattern, rotated each cycle
	always @(negedge clk) begin
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		out_stall = stall_pat[0];
	end

	task automatic test_empty_and_extremes();
		issue_one();
		send_cmd(CMD_ENQUEUE, 2'd3, 3'd7, KIND_WRITE, 32'hFFFF_FFFF);
		send_cmd(CMD_ENQUEUE, 2'd0, 3'd0, KIND_READ, 32'h0000_0000);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd5, 2'd3, 32'h5555_AAAA);
		// Equal stamps: scan order decides
		send_cmd(CMD_ENQUEUE, 2'd2, 3'd1, KIND_RAS, 32'h0000_0010);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd2, KIND_READ, 32'h0000_0010);
		repeat (5) issue_one();
	endtask

	task automatic test_round_robin();
		// RAS then CAS, and a RAS whose bank holds no CAS
		set_config(MODE_RANK_RR, 4'd4, 4'd8, 1'b0);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd3, KIND_RAS, 32'h20);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd3, KIND_READ, 32'h21);
		send_cmd(CMD_ENQUEUE, 2'd2, 3'd6, KIND_RAS, 32'h22);
		repeat (4) issue_one();
		send_cmd(CMD_ENQUEUE, 2'd2, 3'd6, KIND_WRITE, 32'h23);
		issue_one();
		// Grouping with a lone entry and a second entry of each direction
		set_config(MODE_BANK_RR, 4'd2, 4'd3, 1'b1);
		send_cmd(CMD_ENQUEUE, 2'd0, 3'd1, KIND_READ, 32'h30);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd2, KIND_WRITE, 32'h31);
		send_cmd(CMD_ENQUEUE, 2'd1, 3'd2, KIND_READ, 32'h32);
		repeat (4) issue_one();
	endtask

	// Mostly well-formed RAS/CAS pairs, with noise and bare issues mixed in
	task automatic run_traffic(int n);
		int sent, p, nr, nb;
		logic [RANK_W-1:0] r;
		logic [BANK_W-1:0] b;
		sent = 0;
		nr = eff_ranks();
		nb = eff_banks();
		while (sent < n) begin
			p = $urandom_range(0, 99);
			stamp_clock += $urandom_range(1, 50);
			r = RANK_W'($urandom_range(0, nr - 1));
			b = BANK_W'($urandom_range(0, nb - 1));
			if (p < 25) begin
				send_cmd(CMD_ENQUEUE, r, b, KIND_RAS, stamp_clock);
				send_cmd(CMD_ENQUEUE, r, b, KIND_W'($urandom_range(1, 2)), stamp_clock + 1);
				sent += 2;
			end else if (p < 33) begin
				send_cmd(CMD_ENQUEUE, r, b, KIND_W'($urandom_range(1, 2)),
					($urandom_range(0, 15) == 0) ? $urandom : stamp_clock);
				sent++;
			end else if (p < 38) begin
				send_cmd(CMD_ENQUEUE, RANK_W'($urandom), BANK_W'($urandom),
					KIND_W'($urandom), $urandom);
				sent++;
			end else begin
				issue_one();
				sent++;
			end
		end
	endtask

	task automatic test_random_phases();
		logic [MODE_W-1:0] modes [9] = '{MODE_OLDEST, MODE_RANK_RR, MODE_BANK_RR,
			MODE_RANK_RR, MODE_BANK_RR, 2'd3, MODE_OLDEST, MODE_BANK_RR, MODE_RANK_RR};
		logic [CFG_DAT_W-1:0] nrs [9] = '{4'd4, 4'd4, 4'd4, 4'd1, 4'd2, 4'd7, 4'd0, 4'd4, 4'd3};
		logic [CFG_DAT_W-1:0] nbs [9] = '{4'd8, 4'd8, 4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd8, 4'd5};
		logic grp [9] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		for (int ph = 0; ph < 9; ph++) begin
			set_config(modes[ph], nrs[ph], nbs[ph], grp[ph]);
			gap_max = (ph == 0) ? 0 : $urandom_range(1, 12);
			// keep one free cycle in every rotation of the pattern
			stall_pat = (ph == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
			run_traffic(200);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_and_extremes();
		test_round_robin();
		test_random_phases();
		drain();
		repeat (100) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
